// ===== sv/pli_pkg.sv =====
package pli_pkg;

  localparam int ID_W     = 31;
  localparam int OP_W     = 4;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int OCNT_W   = 7;
  // index width covering the largest supported list (1024 entries, plus one)
  localparam int IDX_W    = 11;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_END   = 4'd1,
    OP_INS_POS   = 4'd2,
    OP_RM_FRONT  = 4'd3,
    OP_RM_END    = 4'd4,
    OP_RM_IDX    = 4'd5,
    OP_ROTATE    = 4'd6,
    OP_READ      = 4'd7,
    OP_CLEAR     = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FEW       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_INS,
    MODE_RM,
    MODE_ROT,
    MODE_READ
  } cell_mode_t;

  // broadcast to every cell each accepted beat
  typedef struct packed {
    cell_mode_t       mode;
    logic [IDX_W-1:0] sel;   // insert / remove / read index
    logic [IDX_W-1:0] last;  // index of the last valid entry
  } cell_ctrl_t;

endpackage

// ===== sv/pli_cell.sv =====
module pli_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  pli_pkg::cell_ctrl_t       ctrl,
  input  logic [pli_pkg::ID_W-1:0]  load_val,
  input  logic [pli_pkg::ID_W-1:0]  left_val,
  input  logic [pli_pkg::ID_W-1:0]  right_val,
  output logic [pli_pkg::ID_W-1:0]  val,
  output logic [pli_pkg::ID_W-1:0]  tap
);

  localparam logic [pli_pkg::IDX_W-1:0] MY_IDX = pli_pkg::IDX_W'(IDX);

  logic [pli_pkg::ID_W-1:0] val_next;
  logic                     tap_sel;

  always_comb begin
    val_next = val;
    tap_sel  = 1'b0;
    unique case (ctrl.mode)
      pli_pkg::MODE_INS: begin
        if (MY_IDX == ctrl.sel) begin
          val_next = load_val;
        end else if (MY_IDX > ctrl.sel) begin
          val_next = left_val;
        end
      end
      pli_pkg::MODE_RM: begin
        tap_sel = (MY_IDX == ctrl.sel);
        if (MY_IDX >= ctrl.sel) begin
          val_next = right_val;
        end
      end
      pli_pkg::MODE_ROT: begin
        if (MY_IDX < ctrl.last) begin
          val_next = right_val;
        end else if (MY_IDX == ctrl.last) begin
          val_next = load_val;  // old head wraps to the tail
        end
      end
      pli_pkg::MODE_READ: begin
        tap_sel = (MY_IDX == ctrl.sel);
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= val_next;
      tap <= tap_sel ? val : '0;
    end
  end

endmodule

// ===== sv/pli_or_tree.sv =====
module pli_or_tree #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [pli_pkg::ID_W-1:0]  taps [CAPACITY],
  output logic [pli_pkg::ID_W-1:0]  merged
);

  localparam int GRP  = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  logic [pli_pkg::ID_W-1:0] grp_or   [NGRP];
  logic [pli_pkg::ID_W-1:0] grp_next [NGRP];

  // first level: OR of eight taps per group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < CAPACITY) begin
          grp_next[g] = grp_next[g] | taps[g * GRP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_or <= grp_next;
    end
  end

  // second level: OR of the group registers
  always_comb begin
    merged = '0;
    for (int g = 0; g < NGRP; g++) begin
      merged = merged | grp_or[g];
    end
  end

endmodule

// ===== sv/positional_list_insert_remove.sv =====
// Bounded ordered list of 31-bit IDs held in a row of cells, front at cell 0.
// Each input beat carries one operation (insert front/end/position, remove
// front/end/index, rotate head to tail, read, clear) and yields exactly one
// output beat with status, entry count after the operation and the removed or
// read ID (zero otherwise). All cells shift, hold or load in the accept cycle;
// the selected entry is then gathered by a two-level registered OR tree.
// The result passes from the cell taps through the group registers into the
// output register, which loads when empty or m_tready is high; m_tvalid then
// rises. s_tready stays low while a beat is in the tree, so a new beat is taken
// only once the previous one has left it. The output register lets the next
// beat be accepted while a result waits on m_tready. s_tready is low in reset.
module positional_list_insert_remove #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [3:0] op, [34:4] item_id, [42:35] position, [47:43] zero
  input  logic [pli_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] status, [9:3] entry_count, [40:10] item_out, [47:41] zero
  output logic [pli_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // input fields
  logic [pli_pkg::OP_W-1:0]  op;
  logic [pli_pkg::ID_W-1:0]  item_id;
  logic [pli_pkg::POS_W-1:0] position;

  assign op       = s_tdata[3:0];
  assign item_id  = s_tdata[34:4];
  assign position = s_tdata[42:35];

  // control state
  logic [CNT_W-1:0] count, count_next;
  logic             p1_v, p2_v, out_v;
  logic             accept, adv2;

  // result metadata held while the tree drains (one beat in flight)
  pli_pkg::status_t status, status_next;
  logic [pli_pkg::OCNT_W-1:0] meta_cnt;
  logic [pli_pkg::STATUS_W-1:0] out_status;
  logic [pli_pkg::OCNT_W-1:0]   out_cnt;
  logic [pli_pkg::ID_W-1:0]     out_item;

  // cell row
  pli_pkg::cell_ctrl_t       ctrl;
  logic [pli_pkg::ID_W-1:0]  load_val;
  logic [pli_pkg::ID_W-1:0]  vals [CAPACITY];
  logic [pli_pkg::ID_W-1:0]  taps [CAPACITY];
  logic [pli_pkg::ID_W-1:0]  merged;

  // index arithmetic
  logic [pli_pkg::IDX_W-1:0] cnt_x, pos_x, last_x, ins_k, rm_k, cnt_next_x;

  assign s_tready = !rst && !p1_v && !p2_v;
  assign accept   = s_tvalid && s_tready;
  assign adv2     = p2_v && (!out_v || m_tready);

  always_comb begin
    cnt_x  = pli_pkg::IDX_W'(count);
    pos_x  = pli_pkg::IDX_W'(position);
    last_x = cnt_x - pli_pkg::IDX_W'(1);

    // 1-based insert position: 0 and 1 both mean front, clamp to end
    ins_k = (pos_x == '0) ? '0 : pos_x - pli_pkg::IDX_W'(1);
    if (ins_k > cnt_x) begin
      ins_k = cnt_x;
    end
    // 0-based remove index, clamp to the last entry
    rm_k = (pos_x > last_x) ? last_x : pos_x;

    ctrl.mode   = pli_pkg::MODE_HOLD;
    ctrl.sel    = '0;
    ctrl.last   = last_x;
    load_val    = item_id;
    status_next = pli_pkg::ST_OK;
    count_next  = count;

    unique case (op)
      pli_pkg::OP_INS_FRONT, pli_pkg::OP_INS_END, pli_pkg::OP_INS_POS: begin
        if (count >= CAP_CNT) begin
          status_next = pli_pkg::ST_FULL;
        end else begin
          ctrl.mode  = pli_pkg::MODE_INS;
          count_next = count + CNT_W'(1);
          if (op == pli_pkg::OP_INS_END) begin
            ctrl.sel = cnt_x;
          end else if (op == pli_pkg::OP_INS_POS) begin
            ctrl.sel = ins_k;
          end
        end
      end
      pli_pkg::OP_RM_FRONT, pli_pkg::OP_RM_END, pli_pkg::OP_RM_IDX: begin
        if (count == '0) begin
          status_next = pli_pkg::ST_EMPTY;
        end else begin
          ctrl.mode  = pli_pkg::MODE_RM;
          count_next = count - CNT_W'(1);
          if (op == pli_pkg::OP_RM_END) begin
            ctrl.sel = last_x;
          end else if (op == pli_pkg::OP_RM_IDX) begin
            ctrl.sel = rm_k;
          end
        end
      end
      pli_pkg::OP_ROTATE: begin
        if (count < CNT_W'(2)) begin
          status_next = pli_pkg::ST_FEW;
        end else begin
          ctrl.mode = pli_pkg::MODE_ROT;
          load_val  = vals[0];
        end
      end
      pli_pkg::OP_READ: begin
        if (count == '0) begin
          status_next = pli_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status_next = pli_pkg::ST_RANGE;
        end else begin
          ctrl.mode = pli_pkg::MODE_READ;
          ctrl.sel  = pos_x;
        end
      end
      pli_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // unused codes: no change, status ok
        count_next = count;
      end
    endcase

    cnt_next_x = pli_pkg::IDX_W'(count_next);
  end

  // the row: each cell sees its two neighbors and the broadcast bus
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pli_pkg::ID_W-1:0] left_val, right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_right
      assign right_val = vals[i+1];
    end

    pli_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .en        (accept),
      .ctrl      (ctrl),
      .load_val  (load_val),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (vals[i]),
      .tap       (taps[i])
    );
  end

  pli_or_tree #(
    .CAPACITY (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .adv    (p1_v),
    .taps   (taps),
    .merged (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      p1_v <= accept;
      if (p1_v) begin
        p2_v <= 1'b1;
      end else if (adv2) begin
        p2_v <= 1'b0;
      end
      if (adv2) begin
        out_v <= 1'b1;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      meta_cnt <= cnt_next_x[pli_pkg::OCNT_W-1:0];
    end
    if (adv2) begin
      out_status <= status;
      out_cnt    <= meta_cnt;
      out_item   <= merged;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {7'd0, out_item, out_cnt, out_status};

endmodule

// ===== dv/tb_positional_list_insert_remove.sv =====
`timescale 1ns / 100ps

module tb_positional_list_insert_remove;

  localparam int LIST_CAP   = 64;
  localparam int RAND_ITEMS = 1200;
  // Leaves a wide margin over the slowest legal run, even with both
  // sides stalling hard.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;  // settle time after the last result

  // One pending list operation. drain_first holds the beat back until every
  // outstanding result has come back.
  typedef struct packed {
    logic [pli_pkg::OP_W-1:0]  op;
    logic [pli_pkg::ID_W-1:0]  item_id;
    logic [pli_pkg::POS_W-1:0] position;
    logic                      drain_first;
  } list_req_t;

  typedef struct packed {
    pli_pkg::status_t           status;
    logic [pli_pkg::OCNT_W-1:0] entry_count;
    logic [pli_pkg::ID_W-1:0]   item_out;
  } list_rsp_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  // [3:0] op, [34:4] item_id, [42:35] position, [47:43] zero
  logic [pli_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // [2:0] status, [9:3] entry_count, [40:10] item_out, [47:41] zero
  logic [pli_pkg::OUT_DATA_W-1:0] m_tdata;

  list_req_t pending_ops[$];
  list_rsp_t expected_results[$];

  // Shadow copy of the list, front at index 0.
  logic [pli_pkg::ID_W-1:0] list_ids[LIST_CAP];
  int                       list_len = 0;

  int   errors = 0;
  int   total_items = 0;
  int   beats_sent = 0;
  int   in_flight = 0;   // beats accepted whose result has not yet come back
  int   cycle_cnt = 0;
  logic [1:0] idle_phase = 2'd0;  // 0: sender 29/receiver 57, 1: swapped, 2: none

  positional_list_insert_remove #(.CAPACITY(LIST_CAP)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------

  // Insert at 0-based idx, clamped to the end. Full list leaves all as is.
  function automatic pli_pkg::status_t insert_id(int idx, logic [pli_pkg::ID_W-1:0] id);
    int i;
    if (list_len >= LIST_CAP) return pli_pkg::ST_FULL;
    if (idx > list_len) idx = list_len;
    for (i = list_len; i > idx; i--) list_ids[i] = list_ids[i-1];
    list_ids[idx] = id;
    list_len++;
    return pli_pkg::ST_OK;
  endfunction

  // Remove at 0-based idx, clamped to the last entry.
  function automatic pli_pkg::status_t remove_id(int idx,
                                                 output logic [pli_pkg::ID_W-1:0] id);
    int i;
    id = '0;
    if (list_len == 0) return pli_pkg::ST_EMPTY;
    if (idx > list_len - 1) idx = list_len - 1;
    id = list_ids[idx];
    for (i = idx; i + 1 < list_len; i++) list_ids[i] = list_ids[i+1];
    list_len--;
    return pli_pkg::ST_OK;
  endfunction

  task automatic apply_list_op(input logic [pli_pkg::OP_W-1:0] op,
                               input logic [pli_pkg::ID_W-1:0] id,
                               input logic [pli_pkg::POS_W-1:0] pos,
                               output list_rsp_t rsp);
    pli_pkg::status_t         st;
    logic [pli_pkg::ID_W-1:0] item;
    logic [pli_pkg::ID_W-1:0] head;
    int                       i;
    st   = pli_pkg::ST_OK;
    item = '0;
    case (op)
      pli_pkg::OP_INS_FRONT: st = insert_id(0, id);
      pli_pkg::OP_INS_END:   st = insert_id(list_len, id);
      // position 0 and 1 both mean the front
      pli_pkg::OP_INS_POS:   st = insert_id((pos == 0) ? 0 : int'(pos) - 1, id);
      pli_pkg::OP_RM_FRONT:  st = remove_id(0, item);
      pli_pkg::OP_RM_END:    st = remove_id(list_len, item);
      pli_pkg::OP_RM_IDX:    st = remove_id(int'(pos), item);
      pli_pkg::OP_ROTATE: begin
        if (list_len < 2) begin
          st = pli_pkg::ST_FEW;
        end else begin
          head = list_ids[0];
          for (i = 0; i + 1 < list_len; i++) list_ids[i] = list_ids[i+1];
          list_ids[list_len-1] = head;
        end
      end
      pli_pkg::OP_READ: begin
        if (list_len == 0) st = pli_pkg::ST_EMPTY;
        else if (int'(pos) >= list_len) st = pli_pkg::ST_RANGE;
        else item = list_ids[pos];
      end
      pli_pkg::OP_CLEAR: list_len = 0;
      default: ;  // unused codes: no change
    endcase
    rsp.status      = st;
    rsp.entry_count = pli_pkg::OCNT_W'(list_len);
    rsp.item_out    = item;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic list_req_t mk_req(logic [pli_pkg::OP_W-1:0] op,
                                       logic [pli_pkg::ID_W-1:0] id,
                                       logic [pli_pkg::POS_W-1:0] pos,
                                       logic drain = 1'b0);
    list_req_t r;
    r.op          = op;
    r.item_id     = id;
    r.position    = pos;
    r.drain_first = drain;
    return r;
  endfunction

  // picks one of the three insert ops
  function automatic logic [pli_pkg::OP_W-1:0] OP_OP_W_pick_ins();
    case ($urandom_range(0, 2))
      0:       return pli_pkg::OP_INS_FRONT;
      1:       return pli_pkg::OP_INS_END;
      default: return pli_pkg::OP_INS_POS;
    endcase
  endfunction

  initial begin : stim_proc
    int                        i;
    int                        ins_pct;
    int                        r;
    logic [pli_pkg::OP_W-1:0]  op;
    logic [pli_pkg::ID_W-1:0]  id;
    logic [pli_pkg::POS_W-1:0] pos;

    // Directed: empty-list errors first, then a small list through every op.
    pending_ops.push_back(mk_req(pli_pkg::OP_READ,      '0, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_RM_FRONT,  '0, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_RM_END,    '0, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_RM_IDX,    '0, 8'd255));
    pending_ops.push_back(mk_req(pli_pkg::OP_ROTATE,    '0, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_INS_FRONT, 31'h7fffffff, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_ROTATE,    '0, 8'd0));  // one entry only
    pending_ops.push_back(mk_req(pli_pkg::OP_INS_END,   31'h0, 8'd255));
    pending_ops.push_back(mk_req(pli_pkg::OP_INS_POS,   31'h0000_1111, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_INS_POS,   31'h0000_2222, 8'd1));
    pending_ops.push_back(mk_req(pli_pkg::OP_INS_POS,   31'h5555_5555, 8'd255)); // past end
    pending_ops.push_back(mk_req(pli_pkg::OP_INS_POS,   31'h2aaa_aaaa, 8'd3));
    pending_ops.push_back(mk_req(pli_pkg::OP_READ,      '0, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_READ,      '0, 8'd5));
    pending_ops.push_back(mk_req(pli_pkg::OP_READ,      '0, 8'd6));  // just past count
    pending_ops.push_back(mk_req(pli_pkg::OP_READ,      31'h7fffffff, 8'd255));
    pending_ops.push_back(mk_req(pli_pkg::OP_ROTATE,    '0, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_RM_IDX,    '0, 8'd2));
    pending_ops.push_back(mk_req(pli_pkg::OP_RM_IDX,    '0, 8'd255)); // clamps to last
    pending_ops.push_back(mk_req(pli_pkg::OP_RM_FRONT,  '0, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_RM_END,    '0, 8'd0));
    pending_ops.push_back(mk_req(4'd9,                  31'h1234_5678, 8'd7));
    pending_ops.push_back(mk_req(4'd15,                 31'h7fffffff, 8'd255));
    pending_ops.push_back(mk_req(pli_pkg::OP_CLEAR,     '0, 8'd0));
    pending_ops.push_back(mk_req(pli_pkg::OP_READ,      '0, 8'd0));

    // Random: segments alternate fill-heavy, mixed and drain-heavy so the
    // list swings between empty and full many times.
    for (i = 0; i < RAND_ITEMS; i++) begin
      case ((i / 80) % 4)
        0:       ins_pct = 85;
        2:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      if ($urandom_range(0, 99) < ins_pct) begin
        op = OP_OP_W_pick_ins();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3)       op = pli_pkg::OP_CLEAR;
        else if (r < 7)  op = pli_pkg::OP_W'($urandom_range(9, 15));
        else if (r < 17) op = pli_pkg::OP_ROTATE;
        else if (r < 37) op = pli_pkg::OP_READ;
        else             op = pli_pkg::OP_W'($urandom_range(3, 5));
      end
      // Mostly positions near the live range, now and then anything.
      if ($urandom_range(0, 7) == 0) pos = pli_pkg::POS_W'($urandom_range(0, 255));
      else pos = pli_pkg::POS_W'($urandom_range(0, LIST_CAP + 2));
      case ($urandom_range(0, 15))
        0:       id = '0;
        1:       id = '1;
        default: id = pli_pkg::ID_W'($urandom);
      endcase
      pending_ops.push_back(mk_req(op, id, pos, (i % 150) == 0));
    end
    total_items = pending_ops.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[positional_list_insert_remove] OK");
    end else begin
      $display("[positional_list_insert_remove] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents beats from pending_ops, idles at random per phase.
  // in_flight is tracked here from both handshakes so the drain hold-off
  // does not depend on the checker's update order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    list_req_t req;
    int        idle_pct;
    logic      send;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) in_flight++;
      if (m_tvalid && m_tready) in_flight--;
      if (!s_tvalid || s_tready) begin
        case (idle_phase)
          2'd0:    idle_pct = 29;
          2'd1:    idle_pct = 57;
          default: idle_pct = 0;
        endcase
        send = (pending_ops.size() != 0) && ($urandom_range(0, 99) >= idle_pct);
        if (send && pending_ops[0].drain_first && in_flight != 0) send = 1'b0;
        if (send) begin
          req = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {5'b0, req.position, req.item_id, req.op};
          beats_sent++;
          if (beats_sent * 3 < total_items) idle_phase <= 2'd0;
          else if (beats_sent * 3 < 2 * total_items) idle_phase <= 2'd1;
          else idle_phase <= 2'd2;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks the output beat against the oldest expectation, then
  // predicts the input beat accepted on the same edge (it cannot be the one
  // just checked, the block registers the result before presenting it).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    list_rsp_t                  want;
    list_rsp_t                  pred;
    logic [2:0]                 got_status;
    logic [pli_pkg::OCNT_W-1:0] got_count;
    logic [pli_pkg::ID_W-1:0]   got_item;
    int                         idle_pct;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_status = m_tdata[2:0];
        got_count  = m_tdata[9:3];
        got_item   = m_tdata[40:10];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, actual status=%0d count=%0d item=%h",
                   $time, got_status, got_count, got_item);
        end else begin
          want = expected_results.pop_front();
          if (got_status != want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, got_status);
          end
          if (got_count != want.entry_count) begin
            errors++;
            $display("%0t: entry_count mismatch, expected %0d actual %0d",
                     $time, want.entry_count, got_count);
          end
          if (got_item != want.item_out) begin
            errors++;
            $display("%0t: item_out mismatch, expected %h actual %h",
                     $time, want.item_out, got_item);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_list_op(s_tdata[3:0], s_tdata[34:4], s_tdata[42:35], pred);
        expected_results.push_back(pred);
      end
      case (idle_phase)
        2'd0:    idle_pct = 57;
        2'd1:    idle_pct = 29;
        default: idle_pct = 0;
      endcase
      m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Hard stop if the handshake hangs.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[positional_list_insert_remove] ERROR");
      $finish;
    end
  end

endmodule
